// ----- src/table_linear_interpolator_assert.svh -----
// ----------------------------------------------------------------------------
// table_linear_interpolator_assert.svh
// Assertion macros for the table interpolator checker.
// ----------------------------------------------------------------------------
`ifndef TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TLI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tli_pkg.sv -----
// ----------------------------------------------------------------------------
// tli_pkg
// Types and constants shared by the table interpolator files.
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam int DATA_W = 32;
    localparam int PIDX_W = 6;
    localparam int PIU_W  = 7;
    localparam int STEP_W = $clog2(DATA_W);

    localparam logic [PIU_W-1:0] PIU_RESET = 7'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_INTERP = 2'd0,
        ST_HIT    = 2'd1,
        ST_RANGE  = 2'd2,
        ST_LOAD   = 2'd3
    } status_t;

    typedef struct packed {
        logic                     opcode;
        logic [PIDX_W-1:0]        point_index;
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic signed [DATA_W-1:0] query_x;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_y;
        status_t                  status;
        logic                     saturated;
    } rsp_t;

endpackage

// ----- src/tli_stream_if.sv -----
// ----------------------------------------------------------------------------
// tli_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface tli_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ----- src/table_linear_interpolator.sv -----
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise linear interpolation over a loaded table of Q16.16 points, with
// a bit-serial multiply and divide for the segment arithmetic.
// ----------------------------------------------------------------------------
//  channel   dir   payload   transaction
//  req       in    req_t     load a point or query an abscissa
//  rsp       out   rsp_t     one result per request
//  cfg       in    7 bits    points_in_use, written on cfg_we
//
//  Load: written on accept, answered from S_DONE. Query: range check
//  through S_RD_LAST, S_CHK_LAST and S_CHK_FIRST, then a scan of one table
//  point per cycle, 32 multiply and 32 divide steps, then S_FIN and S_DONE.
//  One request in flight; the output register frees req once it is loaded.
//  Reset clears control state and sets points_in_use to 2; no memory clear.
// ----------------------------------------------------------------------------
module table_linear_interpolator
    import tli_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [PIU_W-1:0] cfg_wdata,
    tli_stream_if.sink       req,
    tli_stream_if.source     rsp
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (NW > PIU_W) ? NW : PIU_W;
    localparam int LW = (NW > PIDX_W) ? NW : PIDX_W;
    localparam int MW = 2 * DATA_W;

    localparam logic signed [DATA_W+1:0] R_MAX = {3'b000, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W+1:0] R_MIN = {3'b111, {(DATA_W-1){1'b0}}};

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_RD_LAST   = 9'b000000010,
        S_CHK_LAST  = 9'b000000100,
        S_CHK_FIRST = 9'b000001000,
        S_SCAN      = 9'b000010000,
        S_MUL       = 9'b000100000,
        S_DIV       = 9'b001000000,
        S_FIN       = 9'b010000000,
        S_DONE      = 9'b100000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [PIU_W-1:0]         piu_reg;
    logic [IW-1:0]            j_reg, j_next;
    logic [STEP_W-1:0]        cnt_reg, cnt_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    logic signed [DATA_W-1:0] q_reg, q_next;
    logic [MW-1:0]            prev_reg, prev_next;
    logic [MW-1:0]            memq_reg;
    logic [DATA_W-1:0]        hi_reg, hi_next;
    logic [DATA_W-1:0]        lo_reg, lo_next;
    logic [DATA_W-1:0]        mc_reg, mc_next;
    logic [DATA_W-1:0]        dx_reg, dx_next;
    logic                     neg_reg, neg_next;
    logic signed [DATA_W-1:0] y0_reg, y0_next;
    rsp_t                     res_reg, res_next;
    rsp_t                     rsp_data_reg, rsp_data_next;

    logic [MW-1:0]            mem [TABLE_DEPTH];
    logic                     mem_we;
    logic [IW-1:0]            wr_addr, rd_addr;

    logic [CW-1:0]            piu_ext, n_eff;
    logic [IW-1:0]            last_idx;
    logic                     idx_ok, accept;

    logic signed [DATA_W-1:0] mq_x, mq_y, pv_x, pv_y;
    logic signed [DATA_W:0]   dy, dq, dx;
    logic [DATA_W:0]          mag;
    logic [DATA_W:0]          mul_sum, div_t, div_d;
    logic                     div_ge, seg, hit;
    logic signed [DATA_W+1:0] y0_ext, quo_ext, r_sum;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    always_comb
    begin
        piu_ext = CW'(piu_reg);
        if (piu_ext < CW'(2))
        begin
            n_eff = CW'(2);
        end
        else if (piu_ext > CW'(TABLE_DEPTH))
        begin
            n_eff = CW'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = piu_ext;
        end
        last_idx = IW'(n_eff - CW'(1));
    end

    assign idx_ok  = LW'(req.data.point_index) < LW'(TABLE_DEPTH);
    assign wr_addr = IW'(req.data.point_index);
    assign mem_we  = accept && (req.data.opcode == OP_LOAD) && idx_ok;

    always_comb
    begin
        unique case (state_reg)
            S_CHK_LAST:  rd_addr = '0;
            S_CHK_FIRST: rd_addr = IW'(1);
            S_SCAN:      rd_addr = j_reg + IW'(1);
            default:     rd_addr = last_idx;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= {req.data.point_x, req.data.point_y};
        end
        memq_reg <= mem[rd_addr];
    end

    assign mq_x = memq_reg[MW-1:DATA_W];
    assign mq_y = memq_reg[DATA_W-1:0];
    assign pv_x = prev_reg[MW-1:DATA_W];
    assign pv_y = prev_reg[DATA_W-1:0];

    // segment set-up: x0 < q < x1 keeps dq and dx positive and below 2^32
    assign dy  = {mq_y[DATA_W-1], mq_y} - {pv_y[DATA_W-1], pv_y};
    assign dq  = {q_reg[DATA_W-1], q_reg} - {pv_x[DATA_W-1], pv_x};
    assign dx  = {mq_x[DATA_W-1], mq_x} - {pv_x[DATA_W-1], pv_x};
    assign mag = dy[DATA_W] ? (DATA_W + 1)'(-dy) : dy;
    assign seg = (pv_x < q_reg) && (q_reg < mq_x);
    assign hit = (q_reg == mq_x);

    // one bit per step: shift-add multiply, then restoring divide
    assign mul_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mc_reg} : '0);
    assign div_t   = {hi_reg, lo_reg[DATA_W-1]};
    assign div_d   = div_t - {1'b0, dx_reg};
    assign div_ge  = (div_t >= {1'b0, dx_reg});

    assign y0_ext  = {{2{y0_reg[DATA_W-1]}}, y0_reg};
    assign quo_ext = {2'b00, lo_reg};
    assign r_sum   = neg_reg ? (y0_ext - quo_ext) : (y0_ext + quo_ext);

    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        q_next         = q_reg;
        prev_next      = prev_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        mc_next        = mc_reg;
        dx_next        = dx_reg;
        neg_next       = neg_reg;
        y0_next        = y0_reg;
        res_next       = res_reg;
        rsp_data_next  = rsp_data_reg;

        if (rsp.valid && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    q_next = req.data.query_x;
                    if (req.data.opcode == OP_LOAD)
                    begin
                        res_next   = '{result_y: '0, status: ST_LOAD, saturated: 1'b0};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RD_LAST;
                    end
                end
            end
            S_RD_LAST:
            begin
                state_next = S_CHK_LAST;
            end
            S_CHK_LAST:
            begin
                if (q_reg > mq_x)
                begin
                    res_next   = '{result_y: '0, status: ST_RANGE, saturated: 1'b0};
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CHK_FIRST;
                end
            end
            S_CHK_FIRST:
            begin
                if (q_reg < mq_x)
                begin
                    res_next   = '{result_y: '0, status: ST_RANGE, saturated: 1'b0};
                    state_next = S_DONE;
                end
                else if (hit)
                begin
                    res_next   = '{result_y: mq_y, status: ST_HIT, saturated: 1'b0};
                    state_next = S_DONE;
                end
                else
                begin
                    prev_next  = memq_reg;
                    j_next     = IW'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (seg)
                begin
                    hi_next    = '0;
                    lo_next    = dq[DATA_W-1:0];
                    mc_next    = mag[DATA_W-1:0];
                    dx_next    = dx[DATA_W-1:0];
                    neg_next   = dy[DATA_W];
                    y0_next    = pv_y;
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
                else if (hit)
                begin
                    res_next   = '{result_y: mq_y, status: ST_HIT, saturated: 1'b0};
                    state_next = S_DONE;
                end
                else if (j_reg == last_idx)
                begin
                    res_next   = '{result_y: '0, status: ST_RANGE, saturated: 1'b0};
                    state_next = S_DONE;
                end
                else
                begin
                    prev_next = memq_reg;
                    j_next    = j_reg + IW'(1);
                end
            end
            S_MUL:
            begin
                hi_next  = mul_sum[DATA_W:1];
                lo_next  = {mul_sum[0], lo_reg[DATA_W-1:1]};
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(DATA_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                hi_next  = div_ge ? div_d[DATA_W-1:0] : div_t[DATA_W-1:0];
                lo_next  = {lo_reg[DATA_W-2:0], div_ge};
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(DATA_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (r_sum > R_MAX)
                begin
                    res_next = '{result_y: R_MAX[DATA_W-1:0], status: ST_INTERP,
                                 saturated: 1'b1};
                end
                else if (r_sum < R_MIN)
                begin
                    res_next = '{result_y: R_MIN[DATA_W-1:0], status: ST_INTERP,
                                 saturated: 1'b1};
                end
                else
                begin
                    res_next = '{result_y: r_sum[DATA_W-1:0], status: ST_INTERP,
                                 saturated: 1'b0};
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            piu_reg       <= PIU_RESET;
            j_reg         <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                piu_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        prev_reg     <= prev_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        mc_reg       <= mc_next;
        dx_reg       <= dx_next;
        neg_reg      <= neg_next;
        y0_reg       <= y0_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule

// ----- src/tli_checker.sv -----
// ----------------------------------------------------------------------------
// tli_checker
// Port-level checks on the table interpolator, bound into the interpolator module.
// ----------------------------------------------------------------------------
`include "table_linear_interpolator_assert.svh"

module tli_checker
    import tli_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    // a stalled result holds
    `TLI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp changed while stalled")

    // one request at a time
    `TLI_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "req taken while busy")

    `TLI_ASSERT_NOW(a_sat_only_interp, rsp_valid && (rsp_data.status != ST_INTERP), !rsp_data.saturated, "saturated flag outside interpolation")

    `TLI_ASSERT_NOW(a_zero_result, rsp_valid && (rsp_data.status == ST_RANGE || rsp_data.status == ST_LOAD), rsp_data.result_y == '0, "non-zero result on range or load")

endmodule

bind table_linear_interpolator tli_checker u_tli_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

// ----- tb/table_linear_interpolator_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// table_linear_interpolator_tb
// Self-checking bench for the table interpolator. The bench loads ascending
// tables of several sizes and queries exact points, segment interiors, edges
// and abscissae outside the span. Every response is checked against a model
// of the table that the bench keeps itself. Both channels see random gaps
// and back-pressure, a long response stall and a full drain pause.
// ---------------------------------------------------------------------------
module table_linear_interpolator_tb;
    import tli_pkg::*;

    localparam int     TABLE_DEPTH  = 64;
    localparam int     CYCLE_LIMIT  = 600000;
    localparam int     DRAIN_CYCLES = 200;
    localparam int     HOLD_AT      = 100;
    localparam int     HOLD_LEN     = 300;
    localparam longint Q_MIN        = -64'sd2147483648;
    localparam longint Q_MAX        = 64'sd2147483647;

    typedef struct packed {
        logic wait_drain;
        req_t txn;
    } queued_req_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [PIU_W-1:0] cfg_wdata;

    tli_stream_if #(.payload_t(req_t)) req_if ();
    tli_stream_if #(.payload_t(rsp_t)) rsp_if ();

    queued_req_t              req_backlog [$];
    rsp_t                     awaited_rsp [$];
    logic signed [DATA_W-1:0] mirror_x [TABLE_DEPTH];
    logic signed [DATA_W-1:0] mirror_y [TABLE_DEPTH];
    logic [PIU_W-1:0]         mirror_count;
    longint                   plan_x [TABLE_DEPTH];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   error_count   = 0;
    int   accepted_reqs = 0;
    int   cycle_count   = 0;
    int   hold_left     = 0;
    bit   hold_done     = 1'b0;
    bit   req_fire      = 1'b0;
    rsp_t got_rsp;
    rsp_t want_rsp;

    table_linear_interpolator #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .req      (req_if),
        .rsp      (rsp_if)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic rsp_t table_response(input req_t txn);
        rsp_t        o;
        int          n;
        int          cnt;
        longint      q;
        longint      x0;
        longint      x1;
        longint      y0;
        longint      dy;
        longint      res;
        logic [63:0] mag;
        logic [63:0] span_q;
        logic [63:0] span_x;
        logic [63:0] quo;
        o.result_y  = '0;
        o.status    = ST_RANGE;
        o.saturated = 1'b0;
        if (txn.opcode == OP_LOAD)
        begin
            mirror_x[txn.point_index] = txn.point_x;
            mirror_y[txn.point_index] = txn.point_y;
            o.status = ST_LOAD;
            return o;
        end
        cnt = int'(mirror_count);
        n = (cnt < 2) ? 2 : (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
        q = longint'($signed(txn.query_x));
        if (q < longint'(mirror_x[0]) || q > longint'(mirror_x[n-1]))
            return o;
        for (int j = 0; j < n; j++)
        begin
            x0 = longint'(mirror_x[j]);
            if (q == x0)
            begin
                o.result_y = mirror_y[j];
                o.status   = ST_HIT;
                return o;
            end
            if (j + 1 < n)
            begin
                x1 = longint'(mirror_x[j+1]);
                if (x0 < q && q < x1)
                begin
                    y0     = longint'(mirror_y[j]);
                    dy     = longint'(mirror_y[j+1]) - y0;
                    span_q = q - x0;
                    span_x = x1 - x0;
                    mag    = (dy < 0) ? -dy : dy;
                    quo    = (mag * span_q) / span_x;
                    res    = (dy < 0) ? y0 - longint'(quo) : y0 + longint'(quo);
                    o.status = ST_INTERP;
                    if (res > Q_MAX)
                    begin
                        res = Q_MAX;
                        o.saturated = 1'b1;
                    end
                    else if (res < Q_MIN)
                    begin
                        res = Q_MIN;
                        o.saturated = 1'b1;
                    end
                    o.result_y = res[DATA_W-1:0];
                    return o;
                end
            end
        end
        return o;
    endfunction

    task automatic offer(input req_t txn, input bit wait_drain);
        queued_req_t entry;
        entry.wait_drain = wait_drain;
        entry.txn        = txn;
        req_backlog.push_back(entry);
    endtask

    task automatic load_point(input int idx, input longint x, input longint y);
        req_t txn;
        txn.opcode      = OP_LOAD;
        txn.point_index = idx[PIDX_W-1:0];
        txn.point_x     = x[DATA_W-1:0];
        txn.point_y     = y[DATA_W-1:0];
        txn.query_x     = $urandom;
        offer(txn, 1'b0);
        plan_x[idx] = longint'($signed(x[DATA_W-1:0]));
    endtask

    task automatic query_at(input longint q, input bit wait_drain = 1'b0);
        req_t txn;
        txn.opcode      = OP_QUERY;
        txn.point_index = PIDX_W'($urandom);
        txn.point_x     = $urandom;
        txn.point_y     = $urandom;
        txn.query_x     = q[DATA_W-1:0];
        offer(txn, wait_drain);
    endtask

    // ascending x: either spread over the whole Q16.16 range or packed near zero
    task automatic build_table(input int n);
        longint steps [TABLE_DEPTH];
        longint total;
        longint base;
        longint cap;
        bit     wide;
        total = 0;
        wide  = $urandom_range(99, 0) < 35;
        if (wide)
            cap = (Q_MAX - Q_MIN) / (n - 1);
        else
            cap = ($urandom_range(3, 0) == 0) ? 64'd4 : 64'd262144;
        for (int i = 1; i < n; i++)
        begin
            steps[i] = 1 + longint'($urandom) % cap;
            total   += steps[i];
        end
        if (wide)
            base = Q_MIN + longint'($urandom) % (Q_MAX - Q_MIN - total + 1);
        else
            base = longint'($urandom_range(33554432, 0)) - 64'sd16777216;
        for (int i = 0; i < n; i++)
        begin
            if (i != 0)
                base += steps[i];
            load_point(i, base, $urandom);
        end
    endtask

    task automatic mixed_traffic(input int n, input int count);
        int     pick;
        int     i;
        longint lo;
        longint hi;
        longint gap;
        repeat (count)
        begin
            pick = $urandom_range(99, 0);
            i    = $urandom_range(n - 2, 0);
            lo   = plan_x[i];
            hi   = plan_x[i+1];
            gap  = hi - lo;
            if (pick < 8)
                load_point($urandom_range(TABLE_DEPTH - 1, 0), $urandom, $urandom);
            else if (pick < 12)
                load_point(i, lo, $urandom);
            else if (pick < 22)
                query_at(plan_x[$urandom_range(n - 1, 0)]);
            else if (pick < 27)
            begin
                lo = plan_x[0];
                query_at((lo > Q_MIN) ? Q_MIN + longint'($urandom) % (lo - Q_MIN) : Q_MIN);
            end
            else if (pick < 32)
            begin
                hi = plan_x[n-1];
                query_at((hi < Q_MAX) ? Q_MAX - longint'($urandom) % (Q_MAX - hi) : Q_MAX);
            end
            else if (pick < 37)
                query_at($urandom);
            else if (gap <= 1)
                query_at(lo);
            else if (pick < 42)
                query_at(lo + 1);
            else if (pick < 47)
                query_at(hi - 1);
            else
                query_at(lo + 1 + longint'($urandom) % (gap - 1));
        end
    endtask

    task automatic settle();
        while (req_backlog.size() != 0 || req_if.valid || awaited_rsp.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_count(input int v);
        settle();
        cfg_we       <= 1'b1;
        cfg_wdata    <= v[PIU_W-1:0];
        mirror_count  = v[PIU_W-1:0];
        @(negedge clk);
        cfg_we       <= 1'b0;
    endtask

    task automatic run_phase(input int cfg, input int count, input bit reload);
        int n;
        n = (cfg < 2) ? 2 : (cfg > TABLE_DEPTH) ? TABLE_DEPTH : cfg;
        write_count(cfg);
        if (reload)
            build_table(n);
        mixed_traffic(n, count);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!req_if.valid || req_fire))
        begin
            if (req_backlog.size() != 0
                && !(req_backlog[0].wait_drain && awaited_rsp.size() != 0)
                && $urandom_range(99, 0) >= send_idle_pct)
            begin
                req_if.data  <= req_backlog[0].txn;
                req_if.valid <= 1'b1;
                void'(req_backlog.pop_front());
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // long response stall, once
    always @(negedge clk)
    begin
        if (!hold_done && accepted_reqs >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            rsp_if.ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // monitor: predict on each request transaction, check each response transaction
    always @(posedge clk)
    begin
        req_fire <= rst_n && req_if.valid && req_if.ready;
        if (rst_n && req_if.valid && req_if.ready)
        begin
            awaited_rsp.push_back(table_response(req_if.data));
            accepted_reqs++;
        end
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got_rsp = rsp_if.data;
            if (awaited_rsp.size() == 0)
            begin
                $error("response with none outstanding: result_y %h status %0d",
                       got_rsp.result_y, got_rsp.status);
                error_count++;
            end
            else
            begin
                want_rsp = awaited_rsp.pop_front();
                if (got_rsp.result_y !== want_rsp.result_y)
                begin
                    $error("result_y: expected %h, actual %h",
                           want_rsp.result_y, got_rsp.result_y);
                    error_count++;
                end
                if (got_rsp.status !== want_rsp.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           want_rsp.status, got_rsp.status);
                    error_count++;
                end
                if (got_rsp.saturated !== want_rsp.saturated)
                begin
                    $error("saturated: expected %0d, actual %0d",
                           want_rsp.saturated, got_rsp.saturated);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        rsp_if.ready  = 1'b0;
        mirror_count  = PIU_RESET;
        send_idle_pct = 10;
        recv_idle_pct = 73;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // full-range segment, reset point count
        load_point(0, Q_MIN, Q_MAX);
        load_point(1, Q_MAX, Q_MIN);
        query_at(Q_MIN);
        query_at(Q_MAX);
        query_at(0);
        query_at(-1);
        query_at(65536);
        // unit segment: both sides out of span, interior and hits
        load_point(0, -65536, 327680);
        load_point(1, 65536, -196608);
        query_at(-65537);
        query_at(65537);
        query_at(0);
        query_at(-65535);
        query_at(65535);
        query_at(-65536);
        query_at(65536);
        // descending x
        load_point(0, 5, 1);
        load_point(1, -5, 2);
        query_at(0);
        query_at(5);
        // flat y
        load_point(0, 0, 7);
        load_point(1, 10, 7);
        query_at(3);

        run_phase(0, 30, 1'b1);
        run_phase(1, 25, 1'b1);
        run_phase(5, 25, 1'b1);
        query_at(plan_x[1], 1'b1);
        mixed_traffic(5, 20);
        run_phase(3, 35, 1'b1);

        settle();
        send_idle_pct = 73;
        recv_idle_pct = 10;
        run_phase(64, 25, 1'b1);
        run_phase(127, 15, 1'b0);
        run_phase(65, 12, 1'b0);
        run_phase(8, 50, 1'b1);

        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(17, 40, 1'b1);
        run_phase(2, 20, 1'b1);
        query_at(plan_x[0], 1'b1);
        mixed_traffic(2, 20);
        run_phase(6, 50, 1'b1);
        run_phase(4, 40, 1'b1);

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/tli_pkg.sv
src/tli_stream_if.sv
src/table_linear_interpolator.sv
src/tli_checker.sv
tb/table_linear_interpolator_tb.sv
